// ===== sv/ricam_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package ricam_pkg;

  localparam int ADDR_BITS   = 26;
  localparam int SIZE_W      = ADDR_BITS + 1;
  localparam int BLOCK_BYTES = 16384;
  localparam int BLOCK_LOG   = $clog2(BLOCK_BYTES);
  localparam int SKIP_W      = 5;

  localparam logic [SIZE_W-1:0] SIZE_CAP = SIZE_W'(1) << ADDR_BITS;
  localparam logic [SIZE_W-1:0] BLOCK_MASK = ~(SIZE_W'(BLOCK_BYTES) - SIZE_W'(1));

  localparam logic [31:0] SIG_HDR16  = 32'h4E45_531A;
  localparam logic [31:0] SIG_PLAIN  = 32'h8037_1240;
  localparam logic [31:0] SIG_SWAP16 = 32'h3780_4012;
  localparam logic [31:0] SIG_SWAP32 = 32'h4012_3780;
  localparam logic [31:0] SIG_MARK   = 32'h5345_4741;
  localparam logic [31:0] XOR_WORD   = 32'h4040_4040;
  localparam logic [7:0]  XOR_KEY    = 8'h40;
  localparam logic [SIZE_W-1:0] MARK_AT    = SIZE_W'(32'h100);
  localparam logic [SIZE_W-1:0] COPIER_HDR = SIZE_W'(512);
  localparam logic [SIZE_W-1:0] HDR16_LEN  = SIZE_W'(16);
  localparam logic [SIZE_W-1:0] XOR_TRIM   = SIZE_W'(5);
  localparam logic [ADDR_BITS-1:0] XOR_SKIP = ADDR_BITS'(4);

  localparam logic [2:0] PLAT_PASS   = 3'd0;
  localparam logic [2:0] PLAT_HDR16  = 3'd1;
  localparam logic [2:0] PLAT_COPIER = 3'd2;
  localparam logic [2:0] PLAT_ORDER  = 3'd3;
  localparam logic [2:0] PLAT_CART   = 3'd4;

  localparam logic [2:0] REG_PLATFORM = 3'd0;
  localparam logic [2:0] REG_FILE_SIZE = 3'd1;
  localparam logic [2:0] REG_HEAD_WORD = 3'd2;
  localparam logic [2:0] REG_MARKER_A = 3'd3;
  localparam logic [2:0] REG_MARKER_B = 3'd4;

  typedef enum logic [2:0] {
    KIND_PLAIN   = 3'd0,
    KIND_HDR16   = 3'd1,
    KIND_HDR512  = 3'd2,
    KIND_SWAP16  = 3'd3,
    KIND_SWAP32  = 3'd4,
    KIND_XOR     = 3'd5,
    KIND_COPIER  = 3'd6,
    KIND_NONE    = 3'd7
  } fmt_kind_t;

  typedef struct packed {
    fmt_kind_t         kind;
    logic [SIZE_W-1:0] len;
    logic [SIZE_W-1:0] size;
    logic [SKIP_W-1:0] skip;
  } fmt_t;

  typedef struct packed {
    logic                 valid;
    logic [ADDR_BITS-1:0] idx;
    fmt_t                 fmt;
  } s1_t;

  typedef struct packed {
    logic                 valid;
    logic [ADDR_BITS-1:0] idx;
    fmt_kind_t            kind;
    logic [SIZE_W-1:0]    len;
    logic                 inr;
    logic                 last;
    logic                 swap_ok;
    logic [ADDR_BITS-1:0] sum;
  } s2_t;

endpackage

`default_nettype wire

// ===== sv/rom_image_canonical_address_map.sv =====
// channel  ports                                   handshake
// input    start, busy, in_out_index               taken when start & !busy
// result   out_valid, out_source_offset .. kind    one-cycle strobe, no hold-off
// config   cfg_we, cfg_index, cfg_data             write when cfg_we high
//
// one word accepted per cycle, busy stays low
// each result is registered in turn by format decode, address
// compute and output select, one register stage each
// synchronous active-low reset clears the config registers and valid bits
// the pipeline never stalls since the receiver always takes the result
`timescale 1ns / 1ps
`default_nettype none

module rom_image_canonical_address_map (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            start,
  output wire logic                            busy,
  input  wire logic [ricam_pkg::ADDR_BITS-1:0] in_out_index,
  output wire logic                            out_valid,
  output wire logic [ricam_pkg::ADDR_BITS-1:0] out_source_offset,
  output wire logic [7:0]                      out_xor_mask,
  output wire logic                            out_force_zero,
  output wire logic                            out_in_range,
  output wire logic                            out_last_byte,
  output wire logic [ricam_pkg::SIZE_W-1:0]    out_content_length,
  output wire logic [2:0]                      out_format_kind,
  input  wire logic                            cfg_we,
  input  wire logic [2:0]                      cfg_index,
  input  wire logic [31:0]                     cfg_data
);

  localparam int AB = ricam_pkg::ADDR_BITS;

  logic [2:0]                   platform_r;
  logic [ricam_pkg::SIZE_W-1:0] file_size_r;
  logic [31:0]                  head_word_r;
  logic [31:0]                  marker_a_r;
  logic [31:0]                  marker_b_r;

  ricam_pkg::s1_t s1;
  ricam_pkg::s2_t s2;

  logic [AB-1:0] src_nxt;
  logic [7:0]    xm_nxt;
  logic          fz_nxt;

  logic                         valid_r;
  logic [AB-1:0]                src_r;
  logic [7:0]                   xm_r;
  logic                         fz_r;
  logic                         inr_r;
  logic                         last_r;
  logic [ricam_pkg::SIZE_W-1:0] len_r;
  ricam_pkg::fmt_kind_t         kind_r;

  assign busy = 1'b0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      platform_r  <= '0;
      file_size_r <= '0;
      head_word_r <= '0;
      marker_a_r  <= '0;
      marker_b_r  <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        ricam_pkg::REG_PLATFORM:  platform_r  <= cfg_data[2:0];
        ricam_pkg::REG_FILE_SIZE: file_size_r <= cfg_data[ricam_pkg::SIZE_W-1:0];
        ricam_pkg::REG_HEAD_WORD: head_word_r <= cfg_data;
        ricam_pkg::REG_MARKER_A:  marker_a_r  <= cfg_data;
        ricam_pkg::REG_MARKER_B:  marker_b_r  <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  ricam_decode u_decode (
    .clk           (clk),
    .rst_n         (rst_n),
    .accept        (start && !busy),
    .idx           (in_out_index),
    .platform      (platform_r),
    .file_size     (file_size_r),
    .head_word     (head_word_r),
    .marker_word_a (marker_a_r),
    .marker_word_b (marker_b_r),
    .s1            (s1)
  );

  ricam_map u_map (
    .clk   (clk),
    .rst_n (rst_n),
    .s1    (s1),
    .s2    (s2)
  );

  always_comb begin
    src_nxt = '0;
    xm_nxt  = '0;
    fz_nxt  = 1'b0;
    if (s2.inr) begin
      unique case (s2.kind)
        ricam_pkg::KIND_SWAP16: begin
          if (s2.swap_ok) src_nxt = s2.idx ^ AB'(1);
          else fz_nxt = 1'b1;
        end
        ricam_pkg::KIND_SWAP32: begin
          if (s2.swap_ok) src_nxt = s2.idx ^ AB'(3);
          else fz_nxt = 1'b1;
        end
        ricam_pkg::KIND_XOR: begin
          src_nxt = s2.sum;
          xm_nxt  = ricam_pkg::XOR_KEY;
        end
        default: src_nxt = s2.sum;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= s2.valid;
    end
  end

  always_ff @(posedge clk) begin
    src_r  <= src_nxt;
    xm_r   <= xm_nxt;
    fz_r   <= fz_nxt;
    inr_r  <= s2.inr;
    last_r <= s2.last;
    len_r  <= s2.len;
    kind_r <= s2.kind;
  end

  assign out_valid          = valid_r;
  assign out_source_offset  = src_r;
  assign out_xor_mask       = xm_r;
  assign out_force_zero     = fz_r;
  assign out_in_range       = inr_r;
  assign out_last_byte      = last_r;
  assign out_content_length = len_r;
  assign out_format_kind    = kind_r;

  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start, 3))
    else $error("result without a word three cycles earlier");

  a_zero_fill: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_force_zero) |->
      (out_in_range && out_source_offset == '0 &&
       (out_format_kind == ricam_pkg::KIND_SWAP16 ||
        out_format_kind == ricam_pkg::KIND_SWAP32)))
    else $error("zero fill outside a swap format");

  a_out_of_range: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_in_range) |->
      (out_source_offset == '0 && out_xor_mask == '0 && !out_force_zero && !out_last_byte))
    else $error("out of range result not cleared");

  a_xor_mask: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_xor_mask != '0) |-> (out_format_kind == ricam_pkg::KIND_XOR))
    else $error("xor mask on a non-xor format");

endmodule

`default_nettype wire

// ===== sv/ricam_decode.sv =====
`timescale 1ns / 1ps
`default_nettype none

module ricam_decode (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           accept,
  input  wire logic [ricam_pkg::ADDR_BITS-1:0] idx,
  input  wire logic [2:0]                     platform,
  input  wire logic [ricam_pkg::SIZE_W-1:0]   file_size,
  input  wire logic [31:0]                    head_word,
  input  wire logic [31:0]                    marker_word_a,
  input  wire logic [31:0]                    marker_word_b,
  output ricam_pkg::s1_t                      s1
);

  ricam_pkg::s1_t  s1_r;
  ricam_pkg::fmt_t fmt_nxt;
  logic [ricam_pkg::SIZE_W-1:0] size;
  logic [ricam_pkg::SKIP_W-1:0] skip;
  logic marked;

  always_comb begin
    size = (file_size > ricam_pkg::SIZE_CAP) ? ricam_pkg::SIZE_CAP : file_size;
    skip = (size < ricam_pkg::HDR16_LEN) ? size[ricam_pkg::SKIP_W-1:0]
                                          : ricam_pkg::SKIP_W'(16);
    marked = (size >= ricam_pkg::MARK_AT + ricam_pkg::SIZE_W'(4)) &&
             (marker_word_a == ricam_pkg::SIG_MARK);
    fmt_nxt.kind = ricam_pkg::KIND_PLAIN;
    fmt_nxt.len  = size;
    fmt_nxt.size = size;
    fmt_nxt.skip = skip;
    unique case (platform)
      ricam_pkg::PLAT_HDR16: begin
        if (size >= ricam_pkg::SIZE_W'(4) && head_word == ricam_pkg::SIG_HDR16) begin
          fmt_nxt.kind = ricam_pkg::KIND_HDR16;
          fmt_nxt.len  = size - ricam_pkg::SIZE_W'(skip);
        end
      end
      ricam_pkg::PLAT_COPIER: begin
        if (size[9:0] == 10'd512) begin
          fmt_nxt.kind = ricam_pkg::KIND_HDR512;
          fmt_nxt.len  = size - ricam_pkg::COPIER_HDR;
        end
      end
      ricam_pkg::PLAT_ORDER: begin
        fmt_nxt.kind = ricam_pkg::KIND_NONE;
        fmt_nxt.len  = '0;
        if (size >= ricam_pkg::SIZE_W'(4)) begin
          priority if (head_word == ricam_pkg::SIG_SWAP16) begin
            fmt_nxt.kind = ricam_pkg::KIND_SWAP16;
            fmt_nxt.len  = size;
          end else if (head_word == ricam_pkg::SIG_SWAP32) begin
            fmt_nxt.kind = ricam_pkg::KIND_SWAP32;
            fmt_nxt.len  = size;
          end else if (head_word == ricam_pkg::SIG_PLAIN) begin
            fmt_nxt.kind = ricam_pkg::KIND_PLAIN;
            fmt_nxt.len  = size;
          end
        end
      end
      ricam_pkg::PLAT_CART: begin
        priority if (size > ricam_pkg::MARK_AT + ricam_pkg::SIZE_W'(8) &&
                     (marker_word_b ^ ricam_pkg::XOR_WORD) == ricam_pkg::SIG_MARK) begin
          fmt_nxt.kind = ricam_pkg::KIND_XOR;
          fmt_nxt.len  = size - ricam_pkg::XOR_TRIM;
        end else if (!marked && size[8:0] == 9'd0 && size[9]) begin
          fmt_nxt.kind = ricam_pkg::KIND_COPIER;
          fmt_nxt.len  = size - ricam_pkg::COPIER_HDR;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_r.valid <= 1'b0;
    end else begin
      s1_r.valid <= accept;
    end
    s1_r.idx <= idx;
    s1_r.fmt <= fmt_nxt;
  end

  assign s1 = s1_r;

endmodule

`default_nettype wire

// ===== sv/ricam_map.sv =====
`timescale 1ns / 1ps
`default_nettype none

module ricam_map (
  input  wire logic   clk,
  input  wire logic   rst_n,
  input  wire ricam_pkg::s1_t s1,
  output ricam_pkg::s2_t s2
);

  localparam int AB = ricam_pkg::ADDR_BITS;
  localparam int BL = ricam_pkg::BLOCK_LOG;

  ricam_pkg::s2_t s2_r;
  ricam_pkg::s2_t s2_nxt;
  logic [ricam_pkg::SIZE_W-1:0] j27;
  logic [ricam_pkg::SIZE_W-1:0] whole;
  logic [AB-1:0] perm;
  logic [AB-1:0] base;
  logic [AB-1:0] addend;

  always_comb begin
    j27   = {1'b0, s1.idx};
    whole = s1.fmt.len & ricam_pkg::BLOCK_MASK;
    perm  = {s1.idx[AB-1:BL], ~s1.idx[0], s1.idx[BL-1:1]};
    base   = s1.idx;
    addend = '0;
    unique case (s1.fmt.kind)
      ricam_pkg::KIND_HDR16:  addend = AB'(s1.fmt.skip);
      ricam_pkg::KIND_HDR512: addend = ricam_pkg::COPIER_HDR[AB-1:0];
      ricam_pkg::KIND_XOR:    addend = ricam_pkg::XOR_SKIP;
      ricam_pkg::KIND_COPIER: begin
        base   = (j27 >= whole) ? s1.idx : perm;
        addend = ricam_pkg::COPIER_HDR[AB-1:0];
      end
      default: addend = '0;
    endcase
    s2_nxt.valid = s1.valid;
    s2_nxt.idx   = s1.idx;
    s2_nxt.kind  = s1.fmt.kind;
    s2_nxt.len   = s1.fmt.len;
    s2_nxt.inr   = j27 < s1.fmt.len;
    s2_nxt.last  = (j27 < s1.fmt.len) && (j27 == s1.fmt.len - ricam_pkg::SIZE_W'(1));
    s2_nxt.swap_ok = (s1.fmt.kind == ricam_pkg::KIND_SWAP32)
                   ? (j27 < {s1.fmt.size[ricam_pkg::SIZE_W-1:2], 2'b00})
                   : (j27 < {s1.fmt.size[ricam_pkg::SIZE_W-1:1], 1'b0});
    s2_nxt.sum   = base + addend;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_r.valid <= 1'b0;
    end else begin
      s2_r.valid <= s2_nxt.valid;
    end
    s2_r.idx     <= s2_nxt.idx;
    s2_r.kind    <= s2_nxt.kind;
    s2_r.len     <= s2_nxt.len;
    s2_r.inr     <= s2_nxt.inr;
    s2_r.last    <= s2_nxt.last;
    s2_r.swap_ok <= s2_nxt.swap_ok;
    s2_r.sum     <= s2_nxt.sum;
  end

  assign s2 = s2_r;

endmodule

`default_nettype wire
